FILE: hdl/alsd_pkg.sv
// ----------------------------------------------------------------------------
// alsd_pkg
// Shared types and codes for the attribute list stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package alsd_pkg;

    localparam logic [7:0] DEFAULT_NAME_SEP  = 8'h3D;
    localparam logic [7:0] DEFAULT_VALUE_SEP = 8'h3B;

    // configuration register indexes
    localparam logic CFG_NAME_SEP  = 1'b0;
    localparam logic CFG_VALUE_SEP = 1'b1;

    // content kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE          = 2'd0;
    localparam logic [1:0] ERR_NO_NAME_TERM  = 2'd1;
    localparam logic [1:0] ERR_MISSING_VALUE = 2'd2;
    localparam logic [1:0] ERR_UNTERMINATED  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       closed_before;
        logic       closed_here;
        logic [1:0] error_code;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] name_sep;
        logic [7:0] value_sep;
    } alsd_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/alsd_cfg.sv
// ----------------------------------------------------------------------------
// alsd_cfg
// Separator registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module alsd_cfg
    import alsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    output alsd_cfg_t       cfg
);

    logic [7:0] name_sep_reg;
    logic [7:0] value_sep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_sep_reg  <= DEFAULT_NAME_SEP;
            value_sep_reg <= DEFAULT_VALUE_SEP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NAME_SEP:  name_sep_reg  <= cfg_data;
                CFG_VALUE_SEP: value_sep_reg <= cfg_data;
                default:       name_sep_reg  <= name_sep_reg;
            endcase
        end
    end

    assign cfg = '{name_sep: name_sep_reg, value_sep: value_sep_reg};

endmodule

`default_nettype wire

FILE: hdl/alsd_step.sv
// ----------------------------------------------------------------------------
// alsd_step
// Parse phase register, byte classification and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alsd_step
    import alsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire in_item_t  in_item,
    input  wire alsd_cfg_t cfg,
    output out_item_t      result
);

    typedef enum logic [1:0] {
        PH_NAME_FIRST,
        PH_NAME_REST,
        PH_VALUE,
        PH_SEP_PENDING
    } phase_t;

    phase_t    phase_reg;
    phase_t    phase_next;
    out_item_t result_reg;
    out_item_t result_next;
    logic      is_name_sep;
    logic      is_value_sep;

    assign is_name_sep  = (in_item.in_byte == cfg.name_sep);
    assign is_value_sep = (in_item.in_byte == cfg.value_sep);

    always_comb
    begin
        result_next.out_byte      = 8'd0;
        result_next.out_kind      = KIND_NONE;
        result_next.closed_before = 1'b0;
        result_next.closed_here   = 1'b0;
        result_next.error_code    = ERR_NONE;
        result_next.out_last      = in_item.in_last;
        phase_next                = phase_reg;

        unique case (phase_reg)
            PH_NAME_REST:
            begin
                if (is_name_sep)
                begin
                    if (in_item.in_last)
                        result_next.error_code = ERR_MISSING_VALUE;
                    phase_next = PH_VALUE;
                end
                else
                begin
                    result_next.out_kind = KIND_NAME;
                    result_next.out_byte = in_item.in_byte;
                    if (in_item.in_last)
                        result_next.error_code = ERR_NO_NAME_TERM;
                end
            end
            PH_VALUE:
            begin
                if (!is_value_sep)
                begin
                    result_next.out_kind = KIND_VALUE;
                    result_next.out_byte = in_item.in_byte;
                    if (in_item.in_last)
                        result_next.error_code = ERR_UNTERMINATED;
                end
                else if (in_item.in_last)
                    result_next.closed_here = 1'b1;
                else
                    phase_next = PH_SEP_PENDING;
            end
            PH_SEP_PENDING:
            begin
                result_next.out_byte = in_item.in_byte;
                if (is_value_sep)
                begin
                    // doubled separator: one literal value byte
                    result_next.out_kind = KIND_VALUE;
                    if (in_item.in_last)
                        result_next.error_code = ERR_UNTERMINATED;
                    phase_next = PH_VALUE;
                end
                else
                begin
                    result_next.closed_before = 1'b1;
                    result_next.out_kind      = KIND_NAME;
                    if (in_item.in_last)
                        result_next.error_code = ERR_NO_NAME_TERM;
                    phase_next = PH_NAME_REST;
                end
            end
            default:
            begin
                // first name byte is taken literally, separators too
                result_next.out_kind = KIND_NAME;
                result_next.out_byte = in_item.in_byte;
                if (in_item.in_last)
                    result_next.error_code = ERR_NO_NAME_TERM;
                phase_next = PH_NAME_REST;
            end
        endcase

        if (in_item.in_last)
            phase_next = PH_NAME_FIRST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_NAME_FIRST;
        else if (advance)
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result = result_reg;

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item.in_last |=> phase_reg == PH_NAME_FIRST)
        else $error("parser did not return to start after final byte");

    a_error_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.error_code != ERR_NONE |=> result_reg.out_last)
        else $error("error reported on a byte that is not final");

    a_close_before_name: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.closed_before
        |=> result_reg.out_kind == KIND_NAME && $past(phase_reg) == PH_SEP_PENDING)
        else $error("attribute close without a pending separator");

    a_close_here_empty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.closed_here
        |=> result_reg.out_kind == KIND_NONE && result_reg.out_last
            && result_reg.error_code == ERR_NONE)
        else $error("final separator close carries content or error");

endmodule

`default_nettype wire

FILE: hdl/attr_list_stream_decoder_top.sv
// An accepted byte goes through the input register, then the result register.
// Throughput: one byte per cycle unless out_stall; the phase register closes a loop.
// An input register and a result register separate the two channels, so a new
// byte is taken while a finished result still waits downstream.
// Reset clears the valid flags and the parse phase and loads the separators
// with '=' and ';'.
// ----------------------------------------------------------------------------
// attr_list_stream_decoder_top
// Streaming decoder for name=value; attribute buffers, one byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

module attr_list_stream_decoder_top
    import alsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    alsd_cfg_t cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    logic      advance;
    logic      load;

    alsd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // move the held byte into the result register when that one is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            in_data_reg <= in_data;
    end

    alsd_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_item (in_data_reg),
        .cfg     (cfg),
        .result  (out_data)
    );

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for attr_list_stream_decoder_top. Byte words from a
// stimulus queue go in with random gaps and output stalls. A bit-accurate
// parser model in the bench predicts every result word, and each result is
// compared field by field. The bench covers directed corner buffers, then
// several separator settings with well-formed, truncated and noise buffers.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alsd_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 20;
    localparam int CALM_FROM = 400;
    localparam int CALM_TO = 750;
    localparam int BYTES_PER_SETTING = 210;

    typedef enum logic [1:0] {PH_FIRST, PH_NAME, PH_VALUE, PH_PENDING} parse_phase_t;
    typedef enum logic [1:0] {ACT_BYTE, ACT_CFG, ACT_DRAIN} stim_op_t;

    typedef struct {
        stim_op_t   op;
        in_item_t   word;
        logic       cfg_idx;
        logic [7:0] cfg_val;
    } stim_act_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_NAME_SEP;
    logic [7:0] cfg_data = 8'h00;

    // parser model state
    parse_phase_t parse_phase = PH_FIRST;
    logic [7:0]   mdl_name_sep = DEFAULT_NAME_SEP;
    logic [7:0]   mdl_value_sep = DEFAULT_VALUE_SEP;

    stim_act_t  byte_plan[$];
    out_item_t  expected_words[$];
    logic [7:0] frame_bytes[$];

    int   bytes_planned = 0;
    int   bytes_accepted = 0;
    int   results_done = 0;
    int   results_seen = 0;
    int   cfg_writes = 0;
    int   drains = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   err_seen[4] = '{0, 0, 0, 0};
    int   closes_before = 0;
    int   closes_here = 0;
    logic calm = 1'b0;

    attr_list_stream_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH: %s", what);
    endtask

    // classify one byte and advance the parse phase
    function automatic out_item_t decode_byte(in_item_t w);
        out_item_t    r;
        parse_phase_t nxt;
        r = '0;
        r.out_kind = KIND_NONE;
        r.error_code = ERR_NONE;
        r.out_last = w.in_last;
        nxt = parse_phase;
        case (parse_phase)
            PH_NAME:
            begin
                if (w.in_byte == mdl_name_sep)
                begin
                    if (w.in_last)
                        r.error_code = ERR_MISSING_VALUE;
                    nxt = PH_VALUE;
                end
                else
                begin
                    r.out_kind = KIND_NAME;
                    r.out_byte = w.in_byte;
                    if (w.in_last)
                        r.error_code = ERR_NO_NAME_TERM;
                end
            end
            PH_VALUE:
            begin
                if (w.in_byte != mdl_value_sep)
                begin
                    r.out_kind = KIND_VALUE;
                    r.out_byte = w.in_byte;
                    if (w.in_last)
                        r.error_code = ERR_UNTERMINATED;
                end
                else if (w.in_last)
                    r.closed_here = 1'b1;
                else
                    nxt = PH_PENDING;
            end
            PH_PENDING:
            begin
                r.out_byte = w.in_byte;
                if (w.in_byte == mdl_value_sep)
                begin
                    // doubled separator is one literal value byte
                    r.out_kind = KIND_VALUE;
                    if (w.in_last)
                        r.error_code = ERR_UNTERMINATED;
                    nxt = PH_VALUE;
                end
                else
                begin
                    r.closed_before = 1'b1;
                    r.out_kind = KIND_NAME;
                    if (w.in_last)
                        r.error_code = ERR_NO_NAME_TERM;
                    nxt = PH_NAME;
                end
            end
            default:
            begin
                // first name byte is taken literally
                r.out_kind = KIND_NAME;
                r.out_byte = w.in_byte;
                if (w.in_last)
                    r.error_code = ERR_NO_NAME_TERM;
                nxt = PH_NAME;
            end
        endcase
        parse_phase = w.in_last ? PH_FIRST : nxt;
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        stim_act_t a;
        a.op = ACT_BYTE;
        a.word.in_byte = b;
        a.word.in_last = last;
        a.cfg_idx = CFG_NAME_SEP;
        a.cfg_val = 8'h00;
        byte_plan.push_back(a);
        bytes_planned++;
    endtask

    task automatic queue_cfg(input logic idx, input logic [7:0] val);
        stim_act_t a;
        a.op = ACT_CFG;
        a.word = '0;
        a.cfg_idx = idx;
        a.cfg_val = val;
        byte_plan.push_back(a);
    endtask

    task automatic queue_drain();
        stim_act_t a;
        a.op = ACT_DRAIN;
        a.word = '0;
        a.cfg_idx = CFG_NAME_SEP;
        a.cfg_val = 8'h00;
        byte_plan.push_back(a);
    endtask

    // send the first cut bytes of the frame, marking the final one
    task automatic queue_frame(input int cut);
        for (int i = 0; i < cut; i++)
            queue_byte(frame_bytes[i], i == cut - 1);
    endtask

    function automatic logic [7:0] pick_other(logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == avoid)
            b = b + 8'd1;
        return b;
    endfunction

    // well-formed name=value; list with random content
    task automatic build_frame(input int attrs, input logic [7:0] ns, input logic [7:0] vs);
        int sel;
        frame_bytes.delete();
        for (int a = 0; a < attrs; a++)
        begin
            sel = $urandom_range(5);
            if (sel == 0)
                frame_bytes.push_back(ns);
            else if (sel == 1)
                frame_bytes.push_back(vs);
            else
                frame_bytes.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(3))
            begin
                if (vs != ns && $urandom_range(5) == 0)
                    frame_bytes.push_back(vs);
                else
                    frame_bytes.push_back(pick_other(ns));
            end
            frame_bytes.push_back(ns);
            repeat ($urandom_range(4))
            begin
                sel = $urandom_range(7);
                if (sel < 2)
                begin
                    frame_bytes.push_back(vs);
                    frame_bytes.push_back(vs);
                end
                else if (sel == 2 && vs != ns)
                    frame_bytes.push_back(ns);
                else
                    frame_bytes.push_back(pick_other(vs));
            end
            frame_bytes.push_back(vs);
        end
    endtask

    task automatic build_noise(input logic [7:0] ns, input logic [7:0] vs);
        int sel;
        frame_bytes.delete();
        repeat ($urandom_range(1, 8))
        begin
            sel = $urandom_range(5);
            if (sel == 0)
                frame_bytes.push_back(ns);
            else if (sel == 1)
                frame_bytes.push_back(vs);
            else
                frame_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // driver: one word in flight, predict at acceptance, config only when idle
    always @(posedge clk)
    begin
        logic      nxt_valid;
        logic      nxt_cfg;
        stim_act_t act;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            nxt_cfg = cfg_valid;
            if (in_valid && !in_stall)
            begin
                expected_words.push_back(decode_byte(in_data));
                bytes_accepted++;
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NAME_SEP)
                    mdl_name_sep = cfg_data;
                else
                    mdl_value_sep = cfg_data;
                cfg_writes++;
                nxt_cfg = 1'b0;
            end
            if (!nxt_valid && !nxt_cfg && byte_plan.size() != 0)
            begin
                act = byte_plan[0];
                case (act.op)
                    ACT_BYTE:
                    begin
                        if (calm || $urandom_range(99) >= 6)
                        begin
                            in_data <= act.word;
                            nxt_valid = 1'b1;
                            void'(byte_plan.pop_front());
                        end
                    end
                    ACT_CFG:
                    begin
                        if (bytes_accepted == results_done)
                        begin
                            cfg_index <= act.cfg_idx;
                            cfg_data <= act.cfg_val;
                            nxt_cfg = 1'b1;
                            void'(byte_plan.pop_front());
                        end
                    end
                    default:
                    begin
                        // hold the sender until every result is back
                        if (bytes_accepted == results_done)
                        begin
                            drains++;
                            void'(byte_plan.pop_front());
                        end
                    end
                endcase
            end
            in_valid <= nxt_valid;
            cfg_valid <= nxt_cfg;
            calm <= bytes_accepted >= CALM_FROM && bytes_accepted < CALM_TO;
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                results_done <= results_done + 1;
                err_seen[out_data.error_code]++;
                if (out_data.closed_before)
                    closes_before++;
                if (out_data.closed_here)
                    closes_here++;
                if (expected_words.size() == 0)
                    flag_mismatch($sformatf("word %0d arrived with nothing expected",
                                            results_seen));
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        flag_mismatch($sformatf("word %0d out_byte %02h, expected %02h",
                                                results_seen, out_data.out_byte,
                                                want.out_byte));
                    if (out_data.out_kind !== want.out_kind)
                        flag_mismatch($sformatf("word %0d out_kind %0d, expected %0d",
                                                results_seen, out_data.out_kind,
                                                want.out_kind));
                    if (out_data.closed_before !== want.closed_before)
                        flag_mismatch($sformatf("word %0d closed_before %b, expected %b",
                                                results_seen, out_data.closed_before,
                                                want.closed_before));
                    if (out_data.closed_here !== want.closed_here)
                        flag_mismatch($sformatf("word %0d closed_here %b, expected %b",
                                                results_seen, out_data.closed_here,
                                                want.closed_here));
                    if (out_data.error_code !== want.error_code)
                        flag_mismatch($sformatf("word %0d error_code %0d, expected %0d",
                                                results_seen, out_data.error_code,
                                                want.error_code));
                    if (out_data.out_last !== want.out_last)
                        flag_mismatch($sformatf("word %0d out_last %b, expected %b",
                                                results_seen, out_data.out_last,
                                                want.out_last));
                end
            end
            out_stall <= !calm && $urandom_range(99) < 6;
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("attr_list_stream_decoder_top regression: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0] set_ns[6];
        logic [7:0] set_vs[6];
        logic [7:0] ns;
        logic [7:0] vs;
        int         target;
        int         pick;
        int         drain_at;

        // directed buffers under the reset separators
        // first name byte is a separator, doubled separator, empty value, closed here
        queue_byte(";", 1'b0);
        queue_byte("=", 1'b0);
        queue_byte("x", 1'b0);
        queue_byte(";", 1'b0);
        queue_byte(";", 1'b0);
        queue_byte(";", 1'b0);
        queue_byte("k", 1'b0);
        queue_byte("=", 1'b0);
        queue_byte(";", 1'b1);
        // lone first name byte as final byte
        queue_byte(8'h00, 1'b1);
        // name byte as final byte
        queue_byte("n", 1'b0);
        queue_byte("m", 1'b1);
        // name separator as final byte
        queue_byte("n", 1'b0);
        queue_byte("=", 1'b1);
        // value byte as final byte
        queue_byte("n", 1'b0);
        queue_byte("=", 1'b0);
        queue_byte(8'hFF, 1'b1);
        // doubled separator as final byte
        queue_byte("n", 1'b0);
        queue_byte("=", 1'b0);
        queue_byte(";", 1'b0);
        queue_byte(";", 1'b1);
        // pending separator, then a name byte that is final
        queue_byte("n", 1'b0);
        queue_byte("=", 1'b0);
        queue_byte(";", 1'b0);
        queue_byte("m", 1'b1);

        set_ns = '{8'h00, 8'hFF, 8'h3D, 8'h00, 8'h00, DEFAULT_NAME_SEP};
        set_vs = '{8'hFF, 8'h00, 8'h3D, 8'h00, 8'h00, DEFAULT_VALUE_SEP};
        set_ns[3] = 8'($urandom_range(255));
        set_vs[3] = 8'($urandom_range(255));
        set_ns[4] = 8'($urandom_range(255));
        set_vs[4] = 8'($urandom_range(255));

        for (int s = 0; s < 6; s++)
        begin
            ns = set_ns[s];
            vs = set_vs[s];
            queue_cfg(CFG_NAME_SEP, ns);
            queue_cfg(CFG_VALUE_SEP, vs);
            target = bytes_planned + BYTES_PER_SETTING;
            drain_at = bytes_planned + BYTES_PER_SETTING / 2;
            while (bytes_planned < target)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                begin
                    build_frame($urandom_range(1, 4), ns, vs);
                    queue_frame(frame_bytes.size());
                end
                else if (pick < 85)
                begin
                    build_frame($urandom_range(1, 3), ns, vs);
                    queue_frame($urandom_range(1, frame_bytes.size()));
                end
                else
                begin
                    build_noise(ns, vs);
                    queue_frame(frame_bytes.size());
                end
                if (drain_at != 0 && bytes_planned >= drain_at)
                begin
                    queue_drain();
                    drain_at = 0;
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (byte_plan.size() != 0 || in_valid || cfg_valid ||
               bytes_accepted != results_done);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_words.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived",
                                    expected_words.size()));

        $display("checked %0d bytes over %0d register writes and %0d drain pauses",
                 results_seen, cfg_writes, drains);
        $display("errors: no name end %0d, missing value %0d, open value %0d; ends %0d/%0d",
                 err_seen[ERR_NO_NAME_TERM], err_seen[ERR_MISSING_VALUE],
                 err_seen[ERR_UNTERMINATED], closes_before, closes_here);
        if (mismatches == 0)
            $display("attr_list_stream_decoder_top regression: pass");
        else
            $display("attr_list_stream_decoder_top regression: fail");
        $finish;
    end

endmodule
